[hw/rtl/bb3_pkg.sv]
// Package for the 3x3 RGB box blur: pixel and stage types, register codes and
// the reciprocal constants of the rounding divide. No dependencies.
`default_nettype none

package bb3_pkg;

   localparam int CFG_BITS       = 11;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;

   // result buffer depth, also the credit limit on the request side
   localparam int OUT_DEPTH = 8;

   localparam int COL_SUM_BITS = 10;  // three 8-bit samples
   localparam int SUM_BITS     = 12;  // nine 8-bit samples
   localparam int NUM_BITS     = 13;  // 2*sum + count
   localparam int RECIP_BITS   = 14;
   localparam int RECIP_SHIFT  = 16;
   localparam int PROD_BITS    = NUM_BITS + RECIP_BITS;

   // ceil(2^16 / (2*n)) for n = 4, 6, 9; exact for every numerator below 4600
   localparam logic [RECIP_BITS-1:0] RECIP_QUAD = 14'd8192;
   localparam logic [RECIP_BITS-1:0] RECIP_EDGE = 14'd5462;
   localparam logic [RECIP_BITS-1:0] RECIP_FULL = 14'd3641;

   localparam logic [3:0] AREA_QUAD = 4'd4;
   localparam logic [3:0] AREA_EDGE = 4'd6;
   localparam logic [3:0] AREA_FULL = 4'd9;

   typedef logic [CFG_BITS-1:0] cfg_type;

   // blue in the low byte, red in the high byte
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // per-item control from the counters to the window stage
   typedef struct packed {
      logic       valid;
      logic       emit;
      logic       pre_shift;   // average the window before this item shifts in
      logic       have_pixel;
      logic [2:0] col_ok;      // bit i: window column i lies in the neighborhood
      logic [2:0] row_ok;      // bit j: window row j lies in the neighborhood
      logic       last;
   } ctl_type;

   // neighborhood snapshot handed to the mean pipeline, index = col*3 + row
   typedef struct packed {
      logic            valid;
      logic            last;
      logic [2:0]      col_ok;
      logic [2:0]      row_ok;
      pixel_type [8:0] pix;
   } win_type;

   typedef struct packed {
      logic      last;
      pixel_type pix;
   } rsp_type;

   function automatic logic [1:0] count3(input logic [2:0] m);
      return {1'b0, m[0]} + {1'b0, m[1]} + {1'b0, m[2]};
   endfunction

endpackage

`default_nettype wire

[hw/rtl/box_blur_3x3_rgb_unit.sv]
// Top level of the 3x3 RGB box blur: frame control, line-buffer window, mean
// pipeline and result buffer. Uses bb3_pkg, bb3_ctl, bb3_window, bb3_mean, bb3_fifo.
//
//   port group  dir  words                         tdata / tuser / tlast
//   req_*       in   pixel or drain word           tdata {red, green, blue}, tuser req_type
//   rsp_*       out  blurred pixel                 tdata {red, green, blue}, tlast frame_last
//   csr_*       in   index 0 width, 1 height       wdata 11 bits, always ready
//
// One word per cycle while req_tready is high; results reach rsp via window, mean, buffer.
// The pace is set by one read and one write per cycle on each line-buffer RAM.
// req_tready drops while 8 results are accepted but not yet taken on rsp.
// Reset is synchronous; line buffers need no clearing pass and start at once.
`default_nettype none

module box_blur_3x3_rgb_unit #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   input  wire logic [23:0]                        req_tdata,   // red_in, green_in, blue_in
   input  wire logic                               req_tuser,   // req_type
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   output      logic [23:0]                        rsp_tdata,   // red_out, green_out, blue_out
   output      logic                               rsp_tlast,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [bb3_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [bb3_pkg::CFG_BITS-1:0]       csr_wdata
);

   localparam int CB = $clog2(MAX_WIDTH);

   bb3_pkg::ctl_type   s0;
   bb3_pkg::win_type   s2;
   bb3_pkg::pixel_type pix;
   bb3_pkg::rsp_type   mean_data, rsp_data;
   logic [CB-1:0]      col;
   logic               mean_valid, rsp_fire;

   assign rsp_fire = rsp_tvalid && rsp_tready;

   bb3_ctl #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (bb3_pkg::pixel_type'(req_tdata)),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (bb3_pkg::cfg_type'(csr_wdata)),
      .rsp_fire   (rsp_fire),
      .col        (col),
      .pix        (pix),
      .s0         (s0)
   );

   bb3_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
      .clock (clock),
      .reset (reset),
      .s0    (s0),
      .col   (col),
      .pix   (pix),
      .s2    (s2)
   );

   bb3_mean u_mean (
      .clock     (clock),
      .reset     (reset),
      .s2        (s2),
      .out_valid (mean_valid),
      .out_data  (mean_data)
   );

   bb3_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (mean_valid),
      .wr_data  (mean_data),
      .rd_valid (rsp_tvalid),
      .rd_ready (rsp_tready),
      .rd_data  (rsp_data)
   );

   assign rsp_tdata = rsp_data.pix;
   assign rsp_tlast = rsp_data.last;

endmodule

`default_nettype wire

[hw/rtl/bb3_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bb3_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/bb3_ctl.sv]
// Frame control: size registers, column/row counters, neighborhood masks and the
// result credit count that gates req_tready. Uses bb3_pkg.
`default_nettype none

module bb3_ctl #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output      logic                                   req_tready,
   input  wire bb3_pkg::pixel_type                     req_tdata,
   input  wire logic                                   req_tuser,
   input  wire logic                                   csr_valid,
   output      logic                                   csr_ready,
   input  wire logic [bb3_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire bb3_pkg::cfg_type                       csr_wdata,
   input  wire logic                                   rsp_fire,
   output      logic [$clog2(MAX_WIDTH)-1:0]           col,
   output      bb3_pkg::pixel_type                     pix,
   output      bb3_pkg::ctl_type                       s0
);

   localparam int CB  = $clog2(MAX_WIDTH);
   localparam int WB  = $clog2(MAX_WIDTH + 1);
   localparam int HB  = $clog2(MAX_HEIGHT + 1);
   localparam int RB  = $clog2(MAX_HEIGHT + 2);   // row runs to height+1 while draining
   localparam int CRB = $clog2(bb3_pkg::OUT_DEPTH + 1);

   bb3_pkg::cfg_type w_ff, w_in, h_ff, h_in;
   logic [CB-1:0]    c_ff, c_in;
   logic [RB-1:0]    r_ff, r_in;
   logic [CRB-1:0]   cr_ff, cr_in;

   logic [WB-1:0] w_eff, c_inc;
   logic [HB-1:0] h_eff;
   logic [RB-1:0] h_ext;
   logic          have_pixel, take, at_col0, pre, post, emit, last, csr_write;

   always_comb begin
      if (w_ff < bb3_pkg::cfg_type'(2)) begin
         w_eff = WB'(2);
      end else if (32'(w_ff) > MAX_WIDTH) begin
         w_eff = WB'(MAX_WIDTH);
      end else begin
         w_eff = WB'(w_ff);
      end
      if (h_ff < bb3_pkg::cfg_type'(2)) begin
         h_eff = HB'(2);
      end else if (32'(h_ff) > MAX_HEIGHT) begin
         h_eff = HB'(MAX_HEIGHT);
      end else begin
         h_eff = HB'(h_ff);
      end
   end

   assign h_ext      = RB'(h_eff);
   assign have_pixel = r_ff < h_ext;
   assign req_tready = cr_ff < CRB'(bb3_pkg::OUT_DEPTH);
   // a drain word during the frame or a pixel word while draining is dropped
   assign take       = req_tvalid && req_tready && (have_pixel != req_tuser);
   assign at_col0    = c_ff == '0;
   // column 0 of row r closes the last pixel of row r-2
   assign pre        = at_col0 && (r_ff >= RB'(2));
   assign post       = !at_col0 && (r_ff >= RB'(1));
   assign emit       = pre || post;
   assign last       = pre && (r_ff == h_ext + RB'(1));
   assign c_inc      = WB'(c_ff) + WB'(1);

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready &&
                      (csr_index == bb3_pkg::REG_IMAGE_WIDTH ||
                       csr_index == bb3_pkg::REG_IMAGE_HEIGHT);

   always_comb begin
      w_in = w_ff;
      h_in = h_ff;
      c_in = c_ff;
      r_in = r_ff;
      if (take) begin
         if (last) begin
            c_in = '0;
            r_in = '0;
         end else if (c_inc >= w_eff) begin
            c_in = '0;
            r_in = r_ff + RB'(1);
         end else begin
            c_in = CB'(c_inc);
         end
      end
      if (csr_write) begin
         if (csr_index == bb3_pkg::REG_IMAGE_WIDTH) begin
            w_in = csr_wdata;
         end else begin
            h_in = csr_wdata;
         end
         c_in = '0;
         r_in = '0;
      end
      cr_in = cr_ff + CRB'(take && emit) - CRB'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff  <= bb3_pkg::cfg_type'(2);
         h_ff  <= bb3_pkg::cfg_type'(2);
         c_ff  <= '0;
         r_ff  <= '0;
         cr_ff <= '0;
      end else begin
         w_ff  <= w_in;
         h_ff  <= h_in;
         c_ff  <= c_in;
         r_ff  <= r_in;
         cr_ff <= cr_in;
      end
   end

   always_comb begin
      s0            = '0;
      s0.valid      = take;
      s0.emit       = emit;
      s0.pre_shift  = pre;
      s0.have_pixel = have_pixel;
      s0.last       = last;
      if (pre) begin
         s0.col_ok = 3'b110;
         s0.row_ok = {r_ff <= h_ext, 1'b1, r_ff >= RB'(3)};
      end else begin
         s0.col_ok = {2'b11, WB'(c_ff) >= WB'(2)};
         s0.row_ok = {r_ff < h_ext, 1'b1, r_ff >= RB'(2)};
      end
   end

   assign col = c_ff;
   assign pix = have_pixel ? req_tdata : '0;

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      cr_ff <= CRB'(bb3_pkg::OUT_DEPTH))
      else $error("result credit above buffer depth");

   a_no_uncredited_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> cr_ff != '0)
      else $error("result delivered without credit");

   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      take && last |=> c_ff == '0 && r_ff == '0)
      else $error("counters not cleared after frame end");

endmodule

`default_nettype wire

[hw/rtl/bb3_window.sv]
// Line buffers and 3x3 window: reads both row RAMs at the item's column, shifts the
// window, writes the rows back and snapshots the neighborhood. Uses bb3_pkg, bb3_ram.
`default_nettype none

module bb3_window #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire bb3_pkg::ctl_type             s0,
   input  wire logic [$clog2(MAX_WIDTH)-1:0] col,
   input  wire bb3_pkg::pixel_type           pix,
   output      bb3_pkg::win_type             s2
);

   localparam int CB = $clog2(MAX_WIDTH);
   localparam int PW = $bits(bb3_pkg::pixel_type);

   bb3_pkg::ctl_type            s1_ff;
   logic [CB-1:0]               s1_col_ff;
   bb3_pkg::pixel_type          s1_pix_ff;
   bb3_pkg::pixel_type [8:0]    win_ff, win_in;
   bb3_pkg::win_type            s2_ff, s2_in;

   logic [PW-1:0] upper_rd, lower_rd;
   logic          wr_en;

   assign wr_en = s1_ff.valid && s1_ff.have_pixel;

   // upper row takes the old lower row, lower row takes the new pixel
   bb3_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_row_upper (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_col_ff),
      .wr_data (lower_rd),
      .rd_addr (col),
      .rd_data (upper_rd)
   );

   bb3_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_row_lower (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_col_ff),
      .wr_data (s1_pix_ff),
      .rd_addr (col),
      .rd_data (lower_rd)
   );

   always_comb begin
      win_in = win_ff;
      if (s1_ff.valid) begin
         win_in[5:0] = win_ff[8:3];
         win_in[6]   = bb3_pkg::pixel_type'(upper_rd);
         win_in[7]   = bb3_pkg::pixel_type'(lower_rd);
         win_in[8]   = s1_pix_ff;
      end
      s2_in        = '0;
      s2_in.valid  = s1_ff.valid && s1_ff.emit;
      s2_in.last   = s1_ff.last;
      s2_in.col_ok = s1_ff.col_ok;
      s2_in.row_ok = s1_ff.row_ok;
      s2_in.pix    = s1_ff.pre_shift ? win_ff : win_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff       <= '0;
         s2_ff.valid <= 1'b0;
      end else begin
         s1_ff       <= s0;
         s2_ff.valid <= s2_in.valid;
      end
      if (s0.valid) begin
         s1_col_ff <= col;
         s1_pix_ff <= pix;
      end
      win_ff       <= win_in;
      s2_ff.last   <= s2_in.last;
      s2_ff.col_ok <= s2_in.col_ok;
      s2_ff.row_ok <= s2_in.row_ok;
      s2_ff.pix    <= s2_in.pix;
   end

   assign s2 = s2_ff;

   // consecutive items sit in different columns, so no read meets a write
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      s0.valid && wr_en |-> col != s1_col_ff)
      else $error("line buffer read and write hit the same column");

endmodule

`default_nettype wire

[hw/rtl/bb3_mean.sv]
// Rounded neighborhood mean: column sums, total plus half-divisor, multiply by the
// reciprocal of 2n. Three register stages. Uses bb3_pkg.
`default_nettype none

module bb3_mean (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire bb3_pkg::win_type s2,
   output      logic             out_valid,
   output      bb3_pkg::rsp_type out_data
);

   localparam int CSB = bb3_pkg::COL_SUM_BITS;
   localparam int SB  = bb3_pkg::SUM_BITS;
   localparam int NB  = bb3_pkg::NUM_BITS;
   localparam int MB  = bb3_pkg::RECIP_BITS;
   localparam int PB  = bb3_pkg::PROD_BITS;

   // column sums
   logic           a_valid_ff, a_last_ff;
   logic [2:0]     a_col_ok_ff;
   logic [1:0]     a_nrows_ff;
   logic [CSB-1:0] a_sum_ff [3][3];   // [column][channel]
   logic [CSB-1:0] a_sum_in [3][3];

   // numerators and reciprocal
   logic          b_valid_ff, b_last_ff;
   logic [NB-1:0] b_x_ff [3];
   logic [NB-1:0] b_x_in [3];
   logic [MB-1:0] b_recip_ff, b_recip_in;

   // products
   logic          c_valid_ff, c_last_ff;
   logic [PB-1:0] c_prod_ff [3];

   logic [1:0]    ncols;
   logic [3:0]    area;
   logic [SB-1:0] total;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int ch = 0; ch < 3; ch++) begin
            a_sum_in[i][ch] = '0;
            for (int j = 0; j < 3; j++) begin
               if (s2.row_ok[j]) begin
                  a_sum_in[i][ch] = a_sum_in[i][ch] + CSB'(s2.pix[i*3+j][8*ch +: 8]);
               end
            end
         end
      end
   end

   always_comb begin
      ncols = bb3_pkg::count3(a_col_ok_ff);
      if (ncols == 2'd3 && a_nrows_ff == 2'd3) begin
         area       = bb3_pkg::AREA_FULL;
         b_recip_in = bb3_pkg::RECIP_FULL;
      end else if (ncols == 2'd3 || a_nrows_ff == 2'd3) begin
         area       = bb3_pkg::AREA_EDGE;
         b_recip_in = bb3_pkg::RECIP_EDGE;
      end else begin
         area       = bb3_pkg::AREA_QUAD;
         b_recip_in = bb3_pkg::RECIP_QUAD;
      end
      total = '0;
      for (int ch = 0; ch < 3; ch++) begin
         total = '0;
         for (int i = 0; i < 3; i++) begin
            if (a_col_ok_ff[i]) begin
               total = total + SB'(a_sum_ff[i][ch]);
            end
         end
         // (2S + n) / (2n) rounds half up
         b_x_in[ch] = {total, 1'b0} + NB'(area);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= s2.valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
      a_last_ff   <= s2.last;
      a_col_ok_ff <= s2.col_ok;
      a_nrows_ff  <= bb3_pkg::count3(s2.row_ok);
      a_sum_ff    <= a_sum_in;
      b_last_ff   <= a_last_ff;
      b_x_ff      <= b_x_in;
      b_recip_ff  <= b_recip_in;
      c_last_ff   <= b_last_ff;
      for (int ch = 0; ch < 3; ch++) begin
         c_prod_ff[ch] <= PB'(b_x_ff[ch]) * PB'(b_recip_ff);
      end
   end

   assign out_valid      = c_valid_ff;
   assign out_data.last  = c_last_ff;
   assign out_data.pix.blue  = c_prod_ff[0][bb3_pkg::RECIP_SHIFT +: 8];
   assign out_data.pix.green = c_prod_ff[1][bb3_pkg::RECIP_SHIFT +: 8];
   assign out_data.pix.red   = c_prod_ff[2][bb3_pkg::RECIP_SHIFT +: 8];

endmodule

`default_nettype wire

[hw/rtl/bb3_fifo.sv]
// Result buffer between the mean pipeline and the rsp stream; its depth matches
// the credit limit in bb3_ctl. Uses bb3_pkg.
`default_nettype none

module bb3_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_valid,
   input  wire bb3_pkg::rsp_type wr_data,
   output      logic             rd_valid,
   input  wire logic             rd_ready,
   output      bb3_pkg::rsp_type rd_data
);

   localparam int PTB = $clog2(bb3_pkg::OUT_DEPTH);
   localparam int CNB = $clog2(bb3_pkg::OUT_DEPTH + 1);

   bb3_pkg::rsp_type mem_ff [bb3_pkg::OUT_DEPTH];
   logic [PTB-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [CNB-1:0]   cnt_ff, cnt_in;
   logic             rd_fire;

   assign rd_valid = cnt_ff != '0;
   assign rd_fire  = rd_valid && rd_ready;
   assign rd_data  = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wr_valid ? wp_ff + PTB'(1) : wp_ff;
      rp_in  = rd_fire ? rp_ff + PTB'(1) : rp_ff;
      cnt_in = cnt_ff + CNB'(wr_valid) - CNB'(rd_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (wr_valid) begin
         mem_ff[wp_ff] <= wr_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      wr_valid |-> cnt_ff != CNB'(bb3_pkg::OUT_DEPTH))
      else $error("result buffer overflow");

   a_count_tracks_ptrs: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != CNB'(bb3_pkg::OUT_DEPTH) |-> PTB'(wp_ff - rp_ff) == PTB'(cnt_ff))
      else $error("result buffer count out of step with pointers");

endmodule

`default_nettype wire
